/* rtl/bdq_pkg.sv */
package bdq_pkg;

    // Field widths of the request and response items.
    localparam int VALUE_W  = 32;
    localparam int TYPE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // Request type codes.
    localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_DELETE     = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_CONTAINS   = 3'd5;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]         req_type;
        logic signed [VALUE_W-1:0] req_value;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] resp_value;
        logic                      hit;
        logic [STATUS_W-1:0]       status;
        logic [OCC_W-1:0]          occupancy;
    } t_resp;

endpackage

/* rtl/bdq_ram.sv */
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/bounded_deque_with_search.sv */
// Channel   Direction  Signals                          Payload
// request   in         i_req_valid / o_req_ready        i_req  (t_req)
// response  out        o_resp_valid / i_resp_ready      o_resp (t_resp)
//
// Push and unused types go from execute to the response state; pop waits for the RAM read first.
// Contains and delete scan one entry per cycle through the single read port
// of the entry RAM; delete then closes the gap with a read/write pass that
// overlaps one read and one write per cycle.
// Reset is synchronous and clears pointers and count; the RAM is not cleared.
// A result waits in the output register, and the next request is taken
// while it waits; only the following result stalls until it is taken.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_req  i_req,
    output logic  o_resp_valid,
    input  logic  i_resp_ready,
    output t_resp o_resp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POPW,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state                    r_state, n_state;
    logic [TYPE_W-1:0]         r_type, n_type;
    logic [VALUE_W-1:0]        r_val, n_val;
    logic [IDX_W-1:0]          r_front, n_front;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_pos, n_pos;
    logic [CNT_W-1:0]          r_cmp_pos, n_cmp_pos;
    logic                      r_pend, n_pend;
    t_resp                     r_res, n_res;
    t_resp                     r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [VALUE_W-1:0]        mem_wdata;
    logic [IDX_W-1:0]          mem_raddr;
    logic [VALUE_W-1:0]        mem_rdata;
    logic                      match;
    logic                      full;

    // Ring slot of a position counted from the front.
    function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    bdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign match = r_pend && (mem_rdata == r_val);
    assign full  = (r_count == CNT_W'(DEPTH));

    // Next-state logic and RAM control.
    always_comb begin
        n_state     = r_state;
        n_type      = r_type;
        n_val       = r_val;
        n_front     = r_front;
        n_count     = r_count;
        n_pos       = r_pos;
        n_cmp_pos   = r_cmp_pos;
        n_pend      = r_pend;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_front;
        mem_wdata   = r_val;
        mem_raddr   = r_front;

        // The output register empties on a transfer.
        if (r_out_valid && i_resp_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_type  = i_req.req_type;
                    n_val   = i_req.req_value;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res           = '0;
                n_res.occupancy = OCC_W'(r_count);
                n_state         = S_RESP;
                unique case (r_type)
                    REQ_PUSH_FRONT: begin
                        if (full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_front = (r_front == '0) ? IDX_W'(DEPTH - 1)
                                                      : r_front - IDX_W'(1);
                            mem_we          = 1'b1;
                            mem_waddr       = n_front;
                            n_count         = r_count + CNT_W'(1);
                            n_res.occupancy = OCC_W'(n_count);
                        end
                    end
                    REQ_PUSH_BACK: begin
                        if (full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            mem_waddr       = ring_slot(r_front, r_count[IDX_W-1:0]);
                            n_count         = r_count + CNT_W'(1);
                            n_res.occupancy = OCC_W'(n_count);
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            if (r_type == REQ_POP_BACK) begin
                                mem_raddr = ring_slot(r_front,
                                                      IDX_W'(r_count - CNT_W'(1)));
                            end
                            n_state = S_POPW;
                        end
                    end
                    REQ_DELETE, REQ_CONTAINS: begin
                        n_pos   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end

            // Read data of the popped entry is valid now.
            S_POPW: begin
                n_res            = '0;
                n_res.resp_value = mem_rdata;
                n_res.hit        = 1'b1;
                n_res.status     = ST_OK;
                n_count          = r_count - CNT_W'(1);
                n_res.occupancy  = OCC_W'(n_count);
                if (r_type == REQ_POP_FRONT) begin
                    n_front = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + IDX_W'(1);
                end
                n_state = S_RESP;
            end

            // One read per cycle; compare the entry read in the previous cycle.
            S_SCAN: begin
                if (match) begin
                    if (r_type == REQ_CONTAINS) begin
                        n_res           = '0;
                        n_res.hit       = 1'b1;
                        n_res.occupancy = OCC_W'(r_count);
                        n_state         = S_RESP;
                    end else begin
                        // r_pos already points at the entry after the match.
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                end else if (r_pos < r_count) begin
                    mem_raddr = ring_slot(r_front, r_pos[IDX_W-1:0]);
                    n_cmp_pos = r_pos;
                    n_pend    = 1'b1;
                    n_pos     = r_pos + CNT_W'(1);
                end else begin
                    n_res           = '0;
                    n_res.status    = ST_NOTFOUND;
                    n_res.occupancy = OCC_W'(r_count);
                    n_state         = S_RESP;
                end
            end

            // Move each later entry one place toward the front.
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = ring_slot(r_front, IDX_W'(r_cmp_pos - CNT_W'(1)));
                    mem_wdata = mem_rdata;
                end
                if (r_pos < r_count) begin
                    mem_raddr = ring_slot(r_front, r_pos[IDX_W-1:0]);
                    n_cmp_pos = r_pos;
                    n_pend    = 1'b1;
                    n_pos     = r_pos + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count         = r_count - CNT_W'(1);
                        n_res           = '0;
                        n_res.hit       = 1'b1;
                        n_res.occupancy = OCC_W'(n_count);
                        n_state         = S_RESP;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            S_RESP: begin
                if (!r_out_valid || i_resp_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, pointers and registered outputs.
    always_ff @(posedge i_clk) begin
        r_type    <= n_type;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_cmp_pos <= n_cmp_pos;
        r_res     <= n_res;
        r_out     <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;

endmodule

/* rtl/bdq_checker.sv */
module bdq_checker
    import bdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_resp_valid,
    input logic  i_resp_ready,
    input t_resp o_resp
);

    // A stalled response holds its payload.
    a_resp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && !i_resp_ready |=> $stable(o_resp))
        else $error("response changed while stalled");

    // After reset no response is offered.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_resp_valid)
        else $error("response valid right after reset");

    // An empty pop leaves the store empty and reports no hit.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && o_resp.status == ST_EMPTY
            |-> o_resp.occupancy == '0 && !o_resp.hit && o_resp.resp_value == '0)
        else $error("empty status with nonzero occupancy or hit");

    // A full push reports the store at its capacity.
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && o_resp.status == ST_FULL
            |-> o_resp.occupancy == OCC_W'(DEPTH) && !o_resp.hit)
        else $error("full status below capacity");

    // A nonzero response value only comes with a successful pop.
    a_value_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && o_resp.resp_value != '0 |-> o_resp.hit && o_resp.status == ST_OK)
        else $error("response value without a hit");

endmodule

bind bounded_deque_with_search bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);
